FILE: hw/rtl/qst_pkg.sv
// Shared types, constants and helpers for the quoted string tokenizer.
package qst_pkg;

	localparam logic [7:0] CH_ESCAPE = 8'h5C;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;

	localparam int NUM_DELIM_REGS = 4;

	localparam logic [15:0] WORD_MAX = 16'hFFFF;

	// configuration register indexes
	localparam logic [2:0] REG_DELIM_A     = 3'd0;
	localparam logic [2:0] REG_DELIM_B     = 3'd1;
	localparam logic [2:0] REG_DELIM_C     = 3'd2;
	localparam logic [2:0] REG_DELIM_D     = 3'd3;
	localparam logic [2:0] REG_DELIM_COUNT = 3'd4;
	localparam logic [2:0] REG_FOLD        = 3'd5;
	localparam logic [2:0] REG_MAX_WORDS   = 3'd6;

	typedef enum logic [1:0] {
		KIND_CHAR = 2'd0,
		KIND_END  = 2'd1,
		KIND_DONE = 2'd2
	} kind_t;

	typedef struct packed {
		logic [7:0] char_byte;
		logic       has_char;
		logic       end_of_string;
	} qst_item_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  out_byte;
		logic [15:0] word_index;
		logic        status;
		logic [15:0] word_total;
		logic        last_result;
	} qst_result_t;

	// Up to three results caused by one input item.
	// mask[0]: character or end of word, mask[1]: final word end, mask[2]: done
	typedef struct packed {
		logic [2:0]  mask;
		logic        first_is_char;
		logic [7:0]  ch;
		logic [15:0] idx0;
		logic [15:0] idx1;
		logic        status;
		logic [15:0] total;
	} qst_entry_t;

	function automatic logic [15:0] sat_inc(input logic [15:0] v);
		sat_inc = (v == WORD_MAX) ? v : v + 16'd1;
	endfunction

endpackage

FILE: hw/rtl/qst_if.sv
// Stream interfaces for input items and result items.
interface qst_item_if import qst_pkg::*; ();
	logic      valid;
	logic      ready;
	qst_item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface qst_result_if import qst_pkg::*; ();
	logic        valid;
	logic        ready;
	qst_result_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

FILE: hw/rtl/quoted_string_tokenizer_top.sv
// Each result group is registered in the queue, then in the back end's register.
// Throughput: one byte per cycle while the queue is not full; an item with k
// results makes k transfers out, the queue (QUEUE_DEPTH groups) absorbing them.
// Reset (arst_n low): registers back to defaults, parse state and queue cleared.
// No clearing pass; items are taken from the first cycle after reset.
module quoted_string_tokenizer_top import qst_pkg::*; #(
	parameter int MAX_DELIMS  = 4,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	qst_item_if.sink    char_in,
	qst_result_if.source tok_out
);

	logic       push, pop, full, empty;
	qst_entry_t push_entry, pop_entry;

	qst_front #(
		.MAX_DELIMS(MAX_DELIMS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.item       (char_in),
		.push       (push),
		.push_entry (push_entry),
		.full       (full)
	);

	qst_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.full       (full),
		.empty      (empty)
	);

	qst_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_entry (pop_entry),
		.q_empty (empty),
		.pop     (pop),
		.result  (tok_out)
	);

endmodule

FILE: hw/rtl/qst_front.sv
// Front end: configuration registers, parse state and classification of each byte.
module qst_front import qst_pkg::*; #(
	parameter int MAX_DELIMS = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [15:0]  cfg_data,
	qst_item_if.sink     item,
	output logic         push,
	output qst_entry_t   push_entry,
	input  logic         full
);

	localparam logic [2:0] MAXD = 3'(MAX_DELIMS);

	logic [7:0]  delim_q [NUM_DELIM_REGS];
	logic [2:0]  delim_count_q;
	logic        fold_q;
	logic [15:0] max_words_q;

	logic        esc_q, dq_q, sq_q, ne_q, lim_q;
	logic [15:0] wc_q;

	logic        acc;
	logic [7:0]  c;
	logic        has, eos;
	logic [2:0]  cnt_eff;
	logic        delim_hit;
	logic        proc, esc_start, chr, dq_tog, sq_tog, dq1, sq1, dlm, emit_char;
	logic        end1, end2, ne1, lim1, esc1;
	logic [15:0] wc1, wc2;

	assign item.ready = !full;
	assign acc = item.valid && item.ready;

	assign c   = item.data.char_byte;
	assign has = item.data.has_char;
	assign eos = item.data.end_of_string;

	assign cnt_eff = (delim_count_q > MAXD) ? MAXD : delim_count_q;

	always_comb begin
		delim_hit = 1'b0;
		for (int i = 0; i < NUM_DELIM_REGS; i++) begin
			if (3'(i) < cnt_eff && delim_q[i] != 8'd0 && delim_q[i] == c)
				delim_hit = 1'b1;
		end
	end

	always_comb begin
		proc      = has && !lim_q;
		esc_start = proc && c == CH_ESCAPE && !esc_q;
		chr       = proc && !esc_start;
		dq_tog    = chr && c == CH_DQUOTE && !esc_q && !sq_q;
		sq_tog    = chr && c == CH_SQUOTE && !esc_q && !dq_q;
		dq1       = dq_q ^ dq_tog;
		sq1       = sq_q ^ sq_tog;
		dlm       = chr && !dq1 && !sq1 && !esc_q && delim_hit;
		emit_char = chr && !dlm && !dq_tog && !sq_tog;
		end1      = dlm && (!fold_q || ne_q);
		wc1       = end1 ? sat_inc(wc_q) : wc_q;
		ne1       = end1 ? 1'b0 : (emit_char ? 1'b1 : ne_q);
		lim1      = lim_q || (end1 && max_words_q != 16'd0 && wc1 == max_words_q);
		end2      = eos && !lim1 && (ne1 || !fold_q);
		wc2       = end2 ? sat_inc(wc1) : wc1;
		esc1      = esc_start ? 1'b1 : (chr ? 1'b0 : esc_q);
	end

	always_comb begin
		push_entry.mask          = {eos, end2, emit_char || end1};
		push_entry.first_is_char = emit_char;
		push_entry.ch            = c;
		push_entry.idx0          = wc_q;
		push_entry.idx1          = wc1;
		push_entry.status        = dq1 || sq1;
		push_entry.total         = wc2;
	end

	assign push = acc && (emit_char || end1 || eos);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_q[0]    <= 8'd32;
			delim_q[1]    <= 8'd44;
			delim_q[2]    <= 8'd0;
			delim_q[3]    <= 8'd0;
			delim_count_q <= 3'd2;
			fold_q        <= 1'b0;
			max_words_q   <= 16'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DELIM_A:     delim_q[0]    <= cfg_data[7:0];
				REG_DELIM_B:     delim_q[1]    <= cfg_data[7:0];
				REG_DELIM_C:     delim_q[2]    <= cfg_data[7:0];
				REG_DELIM_D:     delim_q[3]    <= cfg_data[7:0];
				REG_DELIM_COUNT: delim_count_q <= cfg_data[2:0];
				REG_FOLD:        fold_q        <= cfg_data[0];
				REG_MAX_WORDS:   max_words_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// end of string returns the parse state to reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q <= 1'b0;
			dq_q  <= 1'b0;
			sq_q  <= 1'b0;
			ne_q  <= 1'b0;
			lim_q <= 1'b0;
			wc_q  <= 16'd0;
		end else if (acc) begin
			if (eos) begin
				esc_q <= 1'b0;
				dq_q  <= 1'b0;
				sq_q  <= 1'b0;
				ne_q  <= 1'b0;
				lim_q <= 1'b0;
				wc_q  <= 16'd0;
			end else begin
				esc_q <= esc1;
				dq_q  <= dq1;
				sq_q  <= sq1;
				ne_q  <= ne1;
				lim_q <= lim1;
				wc_q  <= wc1;
			end
		end
	end

endmodule

FILE: hw/rtl/qst_queue.sv
// Small FIFO of result groups between front and back end.
module qst_queue import qst_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  qst_entry_t push_entry,
	input  logic       pop,
	output qst_entry_t pop_entry,
	output logic       full,
	output logic       empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

	qst_entry_t       mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign full      = cnt_q == CNT_W'(DEPTH);
	assign empty     = cnt_q == '0;
	assign pop_entry = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == LAST) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == LAST) ? '0 : rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

FILE: hw/rtl/qst_back.sv
// Back end: unpacks each result group into single results on the output channel.
module qst_back import qst_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  qst_entry_t    q_entry,
	input  logic          q_empty,
	output logic          pop,
	qst_result_if.source  result
);

	qst_entry_t  cur_q;
	logic [2:0]  rem_q;
	logic [2:0]  lowest, rem_after;
	logic        xfer, load;

	assign lowest    = rem_q & (~rem_q + 3'd1);
	assign rem_after = rem_q & ~lowest;

	assign result.valid = |rem_q;
	assign xfer = result.valid && result.ready;
	// refill when idle or when the last pending result goes out
	assign load = (rem_q == 3'd0) || (xfer && rem_after == 3'd0);
	assign pop  = load && !q_empty;

	always_comb begin
		result.data             = '0;
		result.data.last_result = rem_after == 3'd0;
		priority if (rem_q[0]) begin
			result.data.kind       = cur_q.first_is_char ? KIND_CHAR : KIND_END;
			result.data.out_byte   = cur_q.first_is_char ? cur_q.ch : 8'd0;
			result.data.word_index = cur_q.idx0;
		end else if (rem_q[1]) begin
			result.data.kind       = KIND_END;
			result.data.word_index = cur_q.idx1;
		end else begin
			result.data.kind       = KIND_DONE;
			result.data.status     = cur_q.status;
			result.data.word_total = cur_q.total;
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			cur_q <= q_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 3'd0;
		end else if (pop) begin
			rem_q <= q_entry.mask;
		end else if (xfer) begin
			rem_q <= rem_after;
		end
	end

endmodule

FILE: tb/tb_quoted_string_tokenizer_top.sv
// Self-checking testbench for the quoted string tokenizer: directed strings, then random strings.
module tb_quoted_string_tokenizer_top;
	timeunit 1ns;
	timeprecision 1ps;

	import qst_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 8;
	localparam int RANDOM_PHASES  = 6;
	localparam int PHASE_ITEMS    = 36;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_COIN,
		RX_PERIODIC,
		RX_LONG_STALL
	} rx_mode_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	qst_item_if   char_in ();
	qst_result_if tok_out ();

	quoted_string_tokenizer_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.char_in   (char_in),
		.tok_out   (tok_out)
	);

	// shadow registers and parse state
	logic [7:0]  delim_reg [NUM_DELIM_REGS];
	logic [2:0]  delim_used;
	logic        fold_on;
	logic [15:0] word_limit;
	logic        esc_pending;
	logic        in_dq;
	logic        in_sq;
	logic        word_open;
	logic [15:0] word_ctr;
	logic        limit_hit;

	qst_result_t pending_tokens [$];
	qst_result_t step_tokens [$];

	int       mismatches = 0;
	int       token_count = 0;
	int       burst_left = 0;
	int       quiet_cycles = 0;
	int       rx_cycle = 0;
	int       rx_hold = 0;
	rx_mode_t rx_mode = RX_OPEN;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic void clear_parse_state();
		esc_pending = 1'b0;
		in_dq       = 1'b0;
		in_sq       = 1'b0;
		word_open   = 1'b0;
		word_ctr    = 16'h0000;
		limit_hit   = 1'b0;
	endfunction

	function automatic void reset_shadow();
		delim_reg[0] = 8'h20;
		delim_reg[1] = 8'h2C;
		delim_reg[2] = 8'h00;
		delim_reg[3] = 8'h00;
		delim_used   = 3'd2;
		fold_on      = 1'b0;
		word_limit   = 16'h0000;
		clear_parse_state();
	endfunction

	function automatic logic is_delimiter(input logic [7:0] c);
		int n;
		n = (delim_used > NUM_DELIM_REGS) ? NUM_DELIM_REGS : delim_used;
		for (int i = 0; i < n; i++) begin
			if (delim_reg[i] != 8'h00 && delim_reg[i] == c)
				return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void emit(input kind_t k, input logic [7:0] b, input logic [15:0] idx,
			input logic st, input logic [15:0] total);
		qst_result_t r;
		r.kind        = k;
		r.out_byte    = b;
		r.word_index  = idx;
		r.status      = st;
		r.word_total  = total;
		r.last_result = 1'b0;
		step_tokens.push_back(r);
	endfunction

	function automatic void close_word();
		emit(KIND_END, 8'h00, word_ctr, 1'b0, 16'h0000);
		if (word_ctr != 16'hFFFF)
			word_ctr = word_ctr + 16'd1;
		word_open = 1'b0;
		if (word_limit != 16'h0000 && word_ctr == word_limit)
			limit_hit = 1'b1;
	endfunction

	// works out the tokens that one accepted item causes and queues them
	function automatic void tokenize_item(input qst_item_t it);
		logic        quote_flip;
		logic        splits;
		qst_result_t r;
		step_tokens.delete();
		if (it.has_char && !limit_hit) begin
			if (it.char_byte == CH_ESCAPE && !esc_pending) begin
				esc_pending = 1'b1;
			end else begin
				quote_flip = 1'b0;
				if (it.char_byte == CH_DQUOTE && !esc_pending && !in_sq) begin
					in_dq      = !in_dq;
					quote_flip = 1'b1;
				end
				if (it.char_byte == CH_SQUOTE && !esc_pending && !in_dq) begin
					in_sq      = !in_sq;
					quote_flip = 1'b1;
				end
				splits = !in_sq && !in_dq && !esc_pending && is_delimiter(it.char_byte);
				if (!splits) begin
					if (!quote_flip) begin
						emit(KIND_CHAR, it.char_byte, word_ctr, 1'b0, 16'h0000);
						word_open = 1'b1;
					end
				end else if (!fold_on || word_open) begin
					close_word();
				end
				esc_pending = 1'b0;
			end
		end
		if (it.end_of_string) begin
			if (!limit_hit && (word_open || !fold_on))
				close_word();
			emit(KIND_DONE, 8'h00, 16'h0000, in_dq || in_sq, word_ctr);
			clear_parse_state();
		end
		foreach (step_tokens[i]) begin
			r = step_tokens[i];
			r.last_result = (i == step_tokens.size() - 1);
			pending_tokens.push_back(r);
		end
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] token %0d: %s", $time, token_count, msg);
		mismatches++;
	endtask

	// sender: bursts of random length separated by short gaps
	task automatic send_item(input logic [7:0] c, input logic has, input logic eos);
		qst_item_t it;
		it.char_byte     = c;
		it.has_char      = has;
		it.end_of_string = eos;
		if (burst_left == 0) begin
			char_in.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
		end
		burst_left--;
		char_in.valid <= 1'b1;
		char_in.data  <= it;
		@(posedge clk);
		while (!char_in.ready) @(posedge clk);
		tokenize_item(it);
	endtask

	task automatic send_string(input string s, input bit eos_on_last);
		for (int i = 0; i < s.len(); i++)
			send_item(s[i], 1'b1, eos_on_last && i == s.len() - 1);
		if (!eos_on_last || s.len() == 0)
			send_item(8'h00, 1'b0, 1'b1);
	endtask

	// hold the sender until every token is out, then let the pipe settle
	task automatic wait_drained();
		char_in.valid <= 1'b0;
		burst_left = 0;
		while (pending_tokens.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_DELIM_A:     delim_reg[0] = val[7:0];
			REG_DELIM_B:     delim_reg[1] = val[7:0];
			REG_DELIM_C:     delim_reg[2] = val[7:0];
			REG_DELIM_D:     delim_reg[3] = val[7:0];
			REG_DELIM_COUNT: delim_used   = val[2:0];
			REG_FOLD:        fold_on      = val[0];
			REG_MAX_WORDS:   word_limit   = val;
			default: ;
		endcase
	endtask

	function automatic logic [7:0] pick_char();
		logic [7:0] c;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: c = 8'h61 + 8'($urandom_range(0, 25));
			4, 5: begin
				c = delim_reg[$urandom_range(0, NUM_DELIM_REGS - 1)];
				if (c == 8'h00)
					c = 8'h20;
			end
			6: c = CH_DQUOTE;
			7: c = CH_SQUOTE;
			8: c = CH_ESCAPE;
			default: c = 8'($urandom_range(1, 255));
		endcase
		return c;
	endfunction

	task automatic randomise_config(input bit extremes);
		logic [7:0]  pool [8];
		logic [7:0]  d;
		logic [15:0] limit;
		pool = '{8'h20, 8'h2C, 8'h09, 8'h3B, CH_DQUOTE, 8'h00, 8'hFF, 8'h61};
		for (int i = 0; i < NUM_DELIM_REGS; i++) begin
			d = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : pool[$urandom_range(0, 7)];
			write_reg(REG_DELIM_A + 3'(i), {8'h00, d});
		end
		write_reg(REG_DELIM_COUNT, extremes ? 16'd0 : 16'($urandom_range(0, 7)));
		write_reg(REG_FOLD, 16'($urandom_range(0, 1)));
		case ($urandom_range(0, 3))
			0, 1: limit = 16'd0;
			2: limit = 16'($urandom_range(1, 6));
			default: limit = 16'($urandom_range(7, 65535));
		endcase
		write_reg(REG_MAX_WORDS, extremes ? 16'hFFFF : limit);
	endtask

	task automatic test_plain_split();
		// reset delimiters: space and comma; the pair gives an empty word
		send_string("a, b", 1'b1);
	endtask

	task automatic test_quoting();
		send_string("\"a 'b\"\\\"c", 1'b0);
		// open single quote and a trailing escape: error status, escape dropped
		send_string("'x\\", 1'b1);
	endtask

	task automatic test_fold_and_limit();
		wait_drained();
		write_reg(REG_DELIM_A, 16'h002C);
		write_reg(REG_DELIM_COUNT, 16'd1);
		write_reg(REG_FOLD, 16'd1);
		write_reg(REG_MAX_WORDS, 16'd2);
		send_string(",,a,,b,c", 1'b1);
		send_string("x,", 1'b0);
	endtask

	task automatic test_odd_delimiters();
		wait_drained();
		write_reg(REG_DELIM_A, 16'h0000);
		write_reg(REG_DELIM_B, 16'h002C);
		write_reg(REG_DELIM_C, 16'h00FF);
		write_reg(REG_DELIM_D, 16'h0001);
		write_reg(REG_DELIM_COUNT, 16'd7);
		write_reg(REG_FOLD, 16'd0);
		write_reg(REG_MAX_WORDS, 16'd0);
		send_item("x", 1'b1, 1'b0);
		send_item(8'h00, 1'b1, 1'b0);
		send_item(8'hFF, 1'b1, 1'b0);
		send_item(8'hA5, 1'b0, 1'b0);
		send_item("y", 1'b1, 1'b0);
		send_item(8'h01, 1'b1, 1'b0);
		send_item(8'h00, 1'b0, 1'b1);
	endtask

	task automatic test_random_strings();
		int         sent;
		int         len;
		bit         eos_on_char;
		logic       has;
		logic       eos;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			wait_drained();
			randomise_config(phase == 0);
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				if ($urandom_range(0, 9) == 0) begin
					has = 1'($urandom_range(0, 1));
					eos = ($urandom_range(0, 7) == 0);
					send_item(8'($urandom_range(1, 255)), has, eos);
					if (has || eos)
						sent++;
				end else begin
					len = $urandom_range(0, 10);
					eos_on_char = (len != 0) && ($urandom_range(0, 1) == 1);
					for (int i = 0; i < len; i++) begin
						if ($urandom_range(0, 11) == 0)
							send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
						send_item(pick_char(), 1'b1, eos_on_char && i == len - 1);
					end
					if (!eos_on_char)
						send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
					sent += len + (eos_on_char ? 0 : 1);
				end
			end
		end
	endtask

	// receiver: ready pattern is redrawn at random from four modes
	initial begin
		tok_out.ready <= 1'b0;
		forever begin
			@(posedge clk);
			rx_cycle++;
			if (rx_cycle % 256 == 0)
				rx_mode = rx_mode_t'($urandom_range(0, 3));
			case (rx_mode)
				RX_OPEN:     tok_out.ready <= 1'b1;
				RX_COIN:     tok_out.ready <= 1'($urandom_range(0, 1));
				RX_PERIODIC: tok_out.ready <= (rx_cycle % 5) != 0;
				default: begin
					if (rx_hold > 0) begin
						rx_hold--;
						tok_out.ready <= 1'b0;
					end else if ($urandom_range(0, 15) == 0) begin
						rx_hold = $urandom_range(4, 20);
						tok_out.ready <= 1'b0;
					end else begin
						tok_out.ready <= 1'b1;
					end
				end
			endcase
		end
	end

	always @(posedge clk) begin : token_check
		qst_result_t got;
		qst_result_t want;
		if (arst_n && tok_out.valid && tok_out.ready) begin
			got = tok_out.data;
			if (pending_tokens.size() == 0) begin
				report_mismatch($sformatf("unexpected token, kind %0d", int'(got.kind)));
			end else begin
				want = pending_tokens.pop_front();
				if (got.kind != want.kind)
					report_mismatch($sformatf("kind %0d, expected %0d",
						int'(got.kind), int'(want.kind)));
				if (got.out_byte != want.out_byte)
					report_mismatch($sformatf("out_byte %02h, expected %02h",
						got.out_byte, want.out_byte));
				if (got.word_index != want.word_index)
					report_mismatch($sformatf("word_index %0d, expected %0d",
						got.word_index, want.word_index));
				if (got.status != want.status)
					report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
				if (got.word_total != want.word_total)
					report_mismatch($sformatf("word_total %0d, expected %0d",
						got.word_total, want.word_total));
				if (got.last_result != want.last_result)
					report_mismatch($sformatf("last_result %0d, expected %0d",
						got.last_result, want.last_result));
			end
			token_count++;
		end
	end

	// counts cycles without any transfer on either side
	always @(posedge clk) begin
		if ((char_in.valid && char_in.ready) || (tok_out.valid && tok_out.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("[%0t] watchdog: no transfer for %0d cycles, %0d tokens outstanding",
				$time, quiet_cycles, pending_tokens.size());
			$display("FAIL quoted_string_tokenizer_top");
			$finish;
		end
	end

	initial begin
		reset_shadow();
		arst_n        <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_index     <= REG_DELIM_A;
		cfg_data      <= 16'h0000;
		char_in.valid <= 1'b0;
		char_in.data  <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_plain_split();
		test_quoting();
		test_fold_and_limit();
		test_odd_delimiters();
		test_random_strings();

		wait_drained();
		if (mismatches == 0) begin
			$display("PASS quoted_string_tokenizer_top");
		end else begin
			$display("FAIL quoted_string_tokenizer_top");
		end
		$finish;
	end

endmodule

FILE: quoted_string_tokenizer_top.f
hw/rtl/qst_pkg.sv
hw/rtl/qst_if.sv
hw/rtl/qst_front.sv
hw/rtl/qst_queue.sv
hw/rtl/qst_back.sv
hw/rtl/quoted_string_tokenizer_top.sv
tb/tb_quoted_string_tokenizer_top.sv
